>>> design/mrgs_pkg.sv
package mrgs_pkg;

  localparam int NSTAGE = 8;

  typedef struct packed {
    logic [NSTAGE-1:0] load;
    logic [NSTAGE-1:0] valid;
  } pipe_ctl_t;

  localparam logic [15:0] EV_SYNC = 16'd0;
  localparam logic [15:0] EV_KEY  = 16'd1;
  localparam logic [15:0] EV_REL  = 16'd2;

  localparam logic [15:0] CODE_EMIT = 16'd0;

  localparam logic [15:0] REL_X        = 16'd0;
  localparam logic [15:0] REL_Y        = 16'd1;
  localparam logic [15:0] CODE_HSCROLL = 16'd6;
  localparam logic [15:0] CODE_VSCROLL = 16'd8;

  localparam logic [15:0] KEY_LEFT  = 16'h0110;
  localparam logic [15:0] KEY_EXTRA = 16'h0114;

  localparam logic [8:0] GAIN_MIN   = 9'd1;
  localparam logic [8:0] GAIN_MAX   = 9'd500;
  localparam logic [8:0] GAIN_RESET = 9'd100;

  localparam logic signed [35:0] MOVE_LIMIT  = 36'sd32767;
  localparam logic signed [31:0] WHEEL_LIMIT = 32'sd127;

  // ceil(2^35 / 25): exact quotient for dividends below 2^30
  localparam logic [30:0] DIV25_RECIP  = 31'd1374389535;
  // ceil(2^23 / 100): exact quotient for dividends below 2^16
  localparam logic [16:0] DIV100_RECIP = 17'd83887;

  localparam logic [31:0] SCALE_DIV = 32'd100;

endpackage

>>> design/mrgs_axis.sv
module mrgs_axis import mrgs_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  pipe_ctl_t           ctl,
  input  logic signed [31:0]  sum,
  input  logic        [8:0]   gain,
  output logic signed [15:0]  move
);

  // stage 1: magnitude / 100
  logic [31:0]        mag_a;
  logic [60:0]        prod_a;
  logic [31:0]        mag1;
  logic               neg1;
  logic [24:0]        uq1;
  logic [8:0]         gain1;

  // stage 2: signed quotient and remainder of the sum
  logic [31:0]        uq_x100;
  logic [31:0]        ur_full;
  logic [6:0]         ur_b;
  logic signed [25:0] s1_2;
  logic signed [7:0]  s0_2;
  logic [8:0]         gain2;

  // stage 3: gain products
  logic signed [35:0] hi_c;
  logic signed [16:0] lo_c;
  logic signed [35:0] hi3;
  logic signed [16:0] lo3;

  // stage 4: low product / 100
  logic [16:0]        lo_abs;
  logic [15:0]        lmag_d;
  logic [32:0]        lprod_d;
  logic [15:0]        lmag4;
  logic [8:0]         lq4;
  logic               lneg4;
  logic signed [35:0] hi4;

  // stage 5: quotient and remainder without carry
  logic [15:0]        lq_x100;
  logic [15:0]        lr_full;
  logic [6:0]         lr_e;
  logic signed [35:0] lq_s;
  logic signed [35:0] q0_5;
  logic signed [7:0]  r0_5;

  // stage 6: fold in carried remainder
  logic signed [8:0]  t_f;
  logic signed [8:0]  b_f;
  logic signed [35:0] a_f;
  logic signed [35:0] qf_f;
  logic signed [7:0]  carry_next;
  logic signed [35:0] qf6;
  logic               inc6;
  logic signed [7:0]  carry;

  logic signed [35:0] qt;

  always_comb begin
    mag_a  = sum[31] ? (~sum + 32'd1) : sum;
    prod_a = {31'd0, mag_a[31:2]} * {30'd0, DIV25_RECIP};
  end

  always_comb begin
    uq_x100 = {7'd0, uq1} * SCALE_DIV;
    ur_full = mag1 - uq_x100;
    ur_b    = ur_full[6:0];
  end

  always_comb begin
    hi_c = 36'(s1_2) * $signed({27'd0, gain2});
    lo_c = 17'(s0_2) * $signed({8'd0, gain2});
  end

  always_comb begin
    lo_abs  = lo3[16] ? 17'(-lo3) : 17'(lo3);
    lmag_d  = lo_abs[15:0];
    lprod_d = {17'd0, lmag_d} * {16'd0, DIV100_RECIP};
  end

  always_comb begin
    lq_x100 = {7'd0, lq4} * 16'd100;
    lr_full = lmag4 - lq_x100;
    lr_e    = lr_full[6:0];
    lq_s    = $signed({27'd0, lq4});
  end

  always_comb begin
    t_f = 9'(r0_5) + 9'(carry);
    if (t_f >= 9'sd100) begin
      a_f = 36'sd1;
      b_f = t_f - 9'sd100;
    end else if (t_f >= 9'sd0) begin
      a_f = 36'sd0;
      b_f = t_f;
    end else if (t_f >= -9'sd100) begin
      a_f = -36'sd1;
      b_f = t_f + 9'sd100;
    end else begin
      a_f = -36'sd2;
      b_f = t_f + 9'sd200;
    end
    qf_f = q0_5 + a_f;
    if (qf_f[35] && (b_f != 9'sd0)) begin
      carry_next = $signed({1'b0, b_f[6:0]}) - 8'sd100;
    end else begin
      carry_next = $signed({1'b0, b_f[6:0]});
    end
  end

  always_comb begin
    qt = qf6 + $signed({35'd0, inc6});
    if (qt > MOVE_LIMIT) begin
      move = 16'(MOVE_LIMIT);
    end else if (qt < -MOVE_LIMIT) begin
      move = 16'(-MOVE_LIMIT);
    end else begin
      move = qt[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      mag1  <= mag_a;
      neg1  <= sum[31];
      uq1   <= prod_a[59:35];
      gain1 <= gain;
    end
    if (ctl.load[2]) begin
      s1_2  <= neg1 ? -$signed({1'b0, uq1}) : $signed({1'b0, uq1});
      s0_2  <= neg1 ? -$signed({1'b0, ur_b}) : $signed({1'b0, ur_b});
      gain2 <= gain1;
    end
    if (ctl.load[3]) begin
      hi3 <= hi_c;
      lo3 <= lo_c;
    end
    if (ctl.load[4]) begin
      lmag4 <= lmag_d;
      lq4   <= lprod_d[31:23];
      lneg4 <= lo3[16];
      hi4   <= hi3;
    end
    if (ctl.load[5]) begin
      q0_5 <= lneg4 ? (hi4 - lq_s) : (hi4 + lq_s);
      r0_5 <= lneg4 ? -$signed({1'b0, lr_e}) : $signed({1'b0, lr_e});
    end
    if (ctl.load[6]) begin
      qf6  <= qf_f;
      inc6 <= qf_f[35] && (b_f != 9'sd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      carry <= 8'sd0;
    end else if (ctl.load[6] && ctl.valid[5]) begin
      carry <= carry_next;
    end
  end

endmodule

>>> design/mouse_report_gain_scaler_unit.sv
// A report beat leaves after its sync event beat has passed every pipeline stage.
// Throughput: one event beat per cycle while output back-pressure leaves room; the gain
// multiply and divide-by-100 per axis are fully staged; the carry folds in at stage 6.
// Reset clears accumulators, buttons, carries and the pipeline, and loads
// the gain register with 100.
module mouse_report_gain_scaler_unit import mrgs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // event_value
  input  logic [31:0] s_axis_tuser,   // event_type, event_code
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // button_mask, move_x, move_y, wheel_delta,
                                      // hwheel_delta, zero fill
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data
);

  typedef struct packed {
    logic [4:0] btn;
    logic [7:0] wh;
    logic [7:0] hw;
  } side_t;

  logic [15:0]        ev_type;
  logic [15:0]        ev_code;
  logic signed [31:0] ev_value;
  logic               accept;
  logic               sync_acc;

  logic [8:0]         gain_percent;
  logic [8:0]         gain_eff;
  logic [4:0]         held_buttons;
  logic signed [31:0] sum_x;
  logic signed [31:0] sum_y;
  logic signed [31:0] sum_wheel;
  logic signed [31:0] sum_hwheel;
  logic signed [31:0] sum_sel;
  logic signed [31:0] sum_add;
  logic signed [32:0] add_wide;
  logic [2:0]         key_idx;

  logic [NSTAGE-1:0]  vld;
  pipe_ctl_t          ctl;

  logic signed [31:0] sx0;
  logic signed [31:0] sy0;
  logic [8:0]         gain0;
  side_t              side_a;
  side_t              side [0:NSTAGE-2];

  logic signed [15:0] move_x_c;
  logic signed [15:0] move_y_c;
  logic [4:0]         btn7;
  logic [15:0]        mx7;
  logic [15:0]        my7;
  logic [7:0]         wh7;
  logic [7:0]         hw7;

  function automatic logic [7:0] clamp_wheel(input logic signed [31:0] v);
    if (v > WHEEL_LIMIT) begin
      return 8'(WHEEL_LIMIT);
    end else if (v < -WHEEL_LIMIT) begin
      return 8'(-WHEEL_LIMIT);
    end
    return v[7:0];
  endfunction

  assign ev_type   = s_axis_tuser[15:0];
  assign ev_code   = s_axis_tuser[31:16];
  assign ev_value  = s_axis_tdata;
  assign cfg_ready = 1'b1;

  always_comb begin
    ctl.load[NSTAGE-1] = !vld[NSTAGE-1] || m_axis_tready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      ctl.load[k] = !vld[k] || ctl.load[k+1];
    end
    ctl.valid = vld;
  end

  assign s_axis_tready = ctl.load[0];
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign sync_acc      = accept && (ev_type == EV_SYNC) && (ev_code == CODE_EMIT);

  always_comb begin
    if (gain_percent < GAIN_MIN) begin
      gain_eff = GAIN_MIN;
    end else if (gain_percent > GAIN_MAX) begin
      gain_eff = GAIN_MAX;
    end else begin
      gain_eff = gain_percent;
    end
  end

  always_comb begin
    case (ev_code)
      REL_X:        sum_sel = sum_x;
      REL_Y:        sum_sel = sum_y;
      CODE_VSCROLL: sum_sel = sum_wheel;
      CODE_HSCROLL: sum_sel = sum_hwheel;
      default:      sum_sel = 32'sd0;
    endcase
    add_wide = 33'(sum_sel) + 33'(ev_value);
    if (add_wide[32] != add_wide[31]) begin
      sum_add = add_wide[32] ? 32'sh80000000 : 32'sh7fffffff;
    end else begin
      sum_add = add_wide[31:0];
    end
    key_idx = 3'(ev_code - KEY_LEFT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_percent <= GAIN_RESET;
      held_buttons <= 5'd0;
      sum_x        <= 32'sd0;
      sum_y        <= 32'sd0;
      sum_wheel    <= 32'sd0;
      sum_hwheel   <= 32'sd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        gain_percent <= cfg_data;
      end
      if (sync_acc) begin
        sum_x      <= 32'sd0;
        sum_y      <= 32'sd0;
        sum_wheel  <= 32'sd0;
        sum_hwheel <= 32'sd0;
      end else if (accept && (ev_type == EV_REL)) begin
        case (ev_code)
          REL_X:        sum_x      <= sum_add;
          REL_Y:        sum_y      <= sum_add;
          CODE_VSCROLL: sum_wheel  <= sum_add;
          CODE_HSCROLL: sum_hwheel <= sum_add;
          default: ;
        endcase
      end else if (accept && (ev_type == EV_KEY) &&
                   (ev_code inside {[KEY_LEFT:KEY_EXTRA]})) begin
        held_buttons[key_idx] <= (ev_value != 32'sd0);
      end
    end
  end

  always_comb begin
    side_a.btn = held_buttons;
    side_a.wh  = clamp_wheel(sum_wheel);
    side_a.hw  = clamp_wheel(sum_hwheel);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ctl.load[0]) begin
        vld[0] <= sync_acc;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (ctl.load[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      sx0     <= sum_x;
      sy0     <= sum_y;
      gain0   <= gain_eff;
      side[0] <= side_a;
    end
    for (int k = 1; k < NSTAGE - 1; k++) begin
      if (ctl.load[k]) begin
        side[k] <= side[k-1];
      end
    end
    if (ctl.load[NSTAGE-1]) begin
      btn7 <= side[NSTAGE-2].btn;
      mx7  <= move_x_c;
      my7  <= move_y_c;
      wh7  <= side[NSTAGE-2].wh;
      hw7  <= side[NSTAGE-2].hw;
    end
  end

  mrgs_axis u_axis_x (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .sum  (sx0),
    .gain (gain0),
    .move (move_x_c)
  );

  mrgs_axis u_axis_y (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .sum  (sy0),
    .gain (gain0),
    .move (move_y_c)
  );

  assign m_axis_tvalid = vld[NSTAGE-1];
  assign m_axis_tdata  = {3'd0, hw7, wh7, my7, mx7, btn7};

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import mrgs_pkg::*;

  localparam int HALF_PERIOD    = 10;
  localparam int RESET_CYCLES   = 10;
  localparam int DRAIN_CYCLES   = 16;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_ITEMS    = 70;
  localparam int PRESSURE_PHASE = 2;

  localparam logic [15:0] KEY_RIGHT     = KEY_LEFT + 16'd1;
  localparam logic [15:0] KEY_MIDDLE    = KEY_LEFT + 16'd2;
  localparam logic [15:0] KEY_SIDE      = KEY_LEFT + 16'd3;
  localparam logic [15:0] KEY_BELOW     = KEY_LEFT - 16'd1;
  localparam logic [15:0] KEY_ABOVE     = KEY_EXTRA + 16'd1;
  localparam logic [15:0] REL_UNUSED    = 16'd2;
  localparam logic [15:0] SYN_OTHER     = 16'd1;
  localparam logic [15:0] EV_OTHER      = 16'd3;
  localparam logic [15:0] EV_UNUSED_MAX = 16'hFFFF;

  typedef struct packed {
    logic [7:0]  hwheel_delta;
    logic [7:0]  wheel_delta;
    logic [15:0] move_y;
    logic [15:0] move_x;
    logic [4:0]  button_mask;
  } mouse_report_t;

  class report_scoreboard;
    logic [8:0]    gain;
    logic [4:0]    held;
    int            sum_x, sum_y, sum_wheel, sum_hwheel;
    int            carry_x, carry_y;
    mouse_report_t pending_reports[$];
    int            errors;
    int            events_seen;
    int            reports_checked;

    function new();
      gain = GAIN_RESET;
      held = '0;
      sum_x = 0;
      sum_y = 0;
      sum_wheel = 0;
      sum_hwheel = 0;
      carry_x = 0;
      carry_y = 0;
      errors = 0;
      events_seen = 0;
      reports_checked = 0;
    endfunction

    function void set_gain(logic [8:0] g);
      gain = g;
    endfunction

    function int pending();
      return pending_reports.size();
    endfunction

    function int sat_accumulate(int acc, int delta);
      longint s;
      s = longint'(acc) + longint'(delta);
      if (s > longint'(32'sh7FFF_FFFF)) s = longint'(32'sh7FFF_FFFF);
      if (s < longint'(32'sh8000_0000)) s = longint'(32'sh8000_0000);
      return int'(s);
    endfunction

    function logic [15:0] scale_motion(int total, int g, inout int carry);
      longint scaled, quot, lim;
      scaled = longint'(total) * longint'(g) + longint'(carry);
      quot = scaled / longint'(SCALE_DIV);
      carry = int'(scaled - quot * longint'(SCALE_DIV));
      lim = longint'(MOVE_LIMIT);
      if (quot > lim) quot = lim;
      else if (quot < -lim) quot = -lim;
      return quot[15:0];
    endfunction

    function logic [7:0] clamp_wheel(int v);
      if (v > WHEEL_LIMIT) v = WHEEL_LIMIT;
      else if (v < -WHEEL_LIMIT) v = -WHEEL_LIMIT;
      return v[7:0];
    endfunction

    function void note_event(logic [15:0] etype, logic [15:0] code, int value);
      mouse_report_t rep;
      logic [8:0]    g;
      events_seen++;
      case (etype)
        EV_REL: begin
          if (code == REL_X) sum_x = sat_accumulate(sum_x, value);
          else if (code == REL_Y) sum_y = sat_accumulate(sum_y, value);
          else if (code == CODE_VSCROLL) sum_wheel = sat_accumulate(sum_wheel, value);
          else if (code == CODE_HSCROLL) sum_hwheel = sat_accumulate(sum_hwheel, value);
        end
        EV_KEY: begin
          if (code >= KEY_LEFT && code <= KEY_EXTRA) held[code - KEY_LEFT] = (value != 0);
        end
        EV_SYNC: begin
          if (code == CODE_EMIT) begin
            g = gain;
            if (g < GAIN_MIN) g = GAIN_MIN;
            if (g > GAIN_MAX) g = GAIN_MAX;
            rep.button_mask = held;
            rep.move_x = scale_motion(sum_x, int'(g), carry_x);
            rep.move_y = scale_motion(sum_y, int'(g), carry_y);
            rep.wheel_delta = clamp_wheel(sum_wheel);
            rep.hwheel_delta = clamp_wheel(sum_hwheel);
            pending_reports.push_back(rep);
            sum_x = 0;
            sum_y = 0;
            sum_wheel = 0;
            sum_hwheel = 0;
          end
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_report(logic [55:0] beat);
      mouse_report_t want;
      if (pending_reports.size() == 0) begin
        $error("report beat with no report pending: %h", beat);
        errors++;
        return;
      end
      want = pending_reports.pop_front();
      reports_checked++;
      compare_field("button_mask", 16'(want.button_mask), 16'(beat[4:0]));
      compare_field("move_x", want.move_x, beat[20:5]);
      compare_field("move_y", want.move_y, beat[36:21]);
      compare_field("wheel_delta", 16'(want.wheel_delta), 16'(beat[44:37]));
      compare_field("hwheel_delta", 16'(want.hwheel_delta), 16'(beat[52:45]));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [31:0] s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [8:0]  cfg_data = '0;

  report_scoreboard sb;
  bit               sender_steady = 1'b0;
  bit               hold_req = 1'b0;
  bit               hold_on = 1'b0;
  int               holds_done = 0;
  int               gains_written = 0;
  int               idle_cycles = 0;

  mouse_report_gain_scaler_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.set_gain(cfg_data);
      if (s_axis_tvalid && s_axis_tready)
        sb.note_event(s_axis_tuser[15:0], s_axis_tuser[31:16], s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_report(m_axis_tdata);
    end
  end

  always @(posedge clk) begin
    if (rst || (cfg_valid && cfg_ready) || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
      $display("mouse_report_gain_scaler_unit test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int roll;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_on = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on = 1'b0;
        hold_req = 1'b0;
        holds_done++;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
          m_axis_tready <= 1'b1;
          repeat ($urandom_range(50, 150)) @(posedge clk);
        end else if (roll < 70) begin
          m_axis_tready <= 1'b1;
          @(posedge clk);
        end else if (roll < 94) begin
          m_axis_tready <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else begin
          m_axis_tready <= 1'b0;
          repeat ($urandom_range(10, 40)) @(posedge clk);
        end
      end
    end
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (sender_steady || roll < 70) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] pick_delta();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return int'($urandom_range(0, 255)) - 128;
    if (roll < 85) return int'($urandom_range(0, 80000)) - 40000;
    if (roll < 95) return $urandom;
    if (roll < 98) return 32'h7FFF_FFFF;
    return 32'h8000_0000;
  endfunction

  function automatic logic [31:0] pick_key_state();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return '0;
    if (roll < 80) return 32'd1;
    return $urandom;
  endfunction

  task automatic send_event(input logic [15:0] etype, input logic [15:0] code,
                            input logic [31:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= {code, etype};
    s_axis_tdata  <= value;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic send_random(input bit sync_heavy, output bit counted);
    int roll;
    logic [15:0] known_types[3];
    known_types = '{EV_SYNC, EV_KEY, EV_REL};
    roll = $urandom_range(0, 99);
    counted = 1'b1;
    if (sync_heavy) begin
      if (roll < 50) send_event(EV_REL, ($urandom_range(0, 1) ? REL_Y : REL_X), pick_delta());
      else send_event(EV_SYNC, CODE_EMIT, $urandom);
    end else if (roll < 35) begin
      send_event(EV_REL, ($urandom_range(0, 1) ? REL_Y : REL_X), pick_delta());
    end else if (roll < 50) begin
      send_event(EV_REL, ($urandom_range(0, 1) ? CODE_VSCROLL : CODE_HSCROLL), pick_delta());
    end else if (roll < 65) begin
      send_event(EV_KEY, 16'(KEY_LEFT + $urandom_range(0, 4)), pick_key_state());
    end else if (roll < 82) begin
      send_event(EV_SYNC, CODE_EMIT, $urandom);
    end else if (roll < 92) begin
      send_event(16'($urandom), 16'($urandom), $urandom);
      counted = 1'b0;
    end else begin
      send_event(known_types[$urandom_range(0, 2)], 16'($urandom), $urandom);
      counted = 1'b0;
    end
  endtask

  task automatic run_phase(input int n_items, input bit sync_heavy);
    int done;
    bit counted;
    done = 0;
    while (done < n_items) begin
      send_random(sync_heavy, counted);
      if (counted) done++;
    end
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_gain(input logic [8:0] g);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= g;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    gains_written++;
  endtask

  initial begin
    logic [8:0] gains[10];
    sb = new();
    gains = '{9'd1, 9'd500, 9'd0, 9'd511, 9'd37, 9'd250,
              9'($urandom_range(1, 500)), 9'($urandom), 9'd100, 9'd499};
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_event(EV_SYNC, CODE_EMIT, '0);
    send_event(EV_KEY, KEY_LEFT, 32'd1);
    send_event(EV_KEY, KEY_RIGHT, 32'hFFFF_FFFF);
    send_event(EV_KEY, KEY_MIDDLE, 32'h8000_0000);
    send_event(EV_KEY, KEY_SIDE, 32'h7FFF_FFFF);
    send_event(EV_KEY, KEY_EXTRA, 32'd1);
    send_event(EV_KEY, KEY_RIGHT, '0);
    send_event(EV_SYNC, CODE_EMIT, '0);
    send_event(EV_REL, REL_X, 32'h7FFF_FFFF);
    send_event(EV_REL, REL_X, 32'h7FFF_FFFF);
    send_event(EV_REL, REL_Y, 32'h8000_0000);
    send_event(EV_REL, REL_Y, 32'h8000_0000);
    send_event(EV_REL, CODE_VSCROLL, 32'd200);
    send_event(EV_REL, CODE_HSCROLL, -32'sd200);
    send_event(EV_REL, REL_UNUSED, 32'd5);
    send_event(EV_KEY, KEY_BELOW, 32'd1);
    send_event(EV_KEY, KEY_ABOVE, 32'd1);
    send_event(EV_SYNC, SYN_OTHER, '0);
    send_event(EV_OTHER, REL_X, 32'd9);
    send_event(EV_UNUSED_MAX, 16'hFFFF, 32'hFFFF_FFFF);
    send_event(EV_SYNC, CODE_EMIT, '0);
    send_event(EV_REL, REL_X, 32'd1);
    send_event(EV_REL, REL_Y, 32'hFFFF_FFFF);
    send_event(EV_SYNC, CODE_EMIT, '0);
    send_event(EV_SYNC, CODE_EMIT, '0);
    s_axis_tvalid <= 1'b0;

    for (int i = 0; i < 10; i++) begin
      write_gain(gains[i]);
      sender_steady = (i == PRESSURE_PHASE) || (i == 5);
      if (i == PRESSURE_PHASE) begin
        hold_req = 1'b1;
        wait (hold_on);
      end
      run_phase(PHASE_ITEMS, i == PRESSURE_PHASE);
    end

    wait_idle();
    $display("covered %0d events and %0d reports over %0d gain writes (0, 1, 500, 511 included)",
             sb.events_seen, sb.reports_checked, gains_written);
    $display("output held off for %0d long stretches while input kept streaming", holds_done);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("mouse_report_gain_scaler_unit test passed");
    end else begin
      $display("mouse_report_gain_scaler_unit test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
design/mrgs_pkg.sv
design/mrgs_axis.sv
design/mouse_report_gain_scaler_unit.sv
verif/tb_top.sv
